>>> src/ftfm_pkg.sv
package ftfm_pkg;

  localparam int unsigned SINE_ADDR_BITS = 12;
  localparam int unsigned SAMPLE_WIDTH   = 16;

  localparam int unsigned QTR_BITS   = SINE_ADDR_BITS - 2;
  localparam int unsigned QTR_SIZE   = 1 << QTR_BITS;
  localparam int unsigned ROM_AW     = QTR_BITS + 1;
  localparam int unsigned MAG_W      = SAMPLE_WIDTH - 1;
  localparam int unsigned AMPLITUDE  = (1 << (SAMPLE_WIDTH - 1)) - 1;
  localparam real         PI         = 3.14159265358979323846;
  localparam real         QTR_STEP   = PI / 2.0 / real'(QTR_SIZE);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2,
    OP_END   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_START = 2'd1,
    MODE_DATA  = 2'd2,
    MODE_END   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_SAMPLES  = 3'd0,
    REG_INC_ONE       = 3'd1,
    REG_INC_ZERO      = 3'd2,
    REG_INC_SEPARATOR = 3'd3,
    REG_INC_START     = 3'd4,
    REG_INC_END       = 3'd5
  } reg_idx_e;

  localparam logic [15:0] TONE_SAMPLES_RST  = 16'd2400;
  localparam logic [30:0] INC_ONE_RST       = 31'd1789569707;
  localparam logic [30:0] INC_ZERO_RST      = 31'd1968526677;
  localparam logic [30:0] INC_SEPARATOR_RST = 31'd1879048192;
  localparam logic [30:0] INC_START_RST     = 31'd1834308949;
  localparam logic [30:0] INC_END_RST       = 31'd1923787435;

  typedef struct packed {
    logic [15:0] tone_samples;
    logic [30:0] inc_one;
    logic [30:0] inc_zero;
    logic [30:0] inc_separator;
    logic [30:0] inc_start;
    logic [30:0] inc_end;
  } cfg_t;

  // Per-word flags handed from the sequencer down the sample pipeline
  typedef struct packed {
    logic sample_valid;
    logic last;
    logic accepted;
    logic busy;
    logic negate;
  } flags_t;

  typedef logic [MAG_W-1:0] qtr_rom_t [0:QTR_SIZE];

  // Quarter-wave magnitudes: round(A * sin(pi/2 * k / QTR_SIZE))
  function automatic qtr_rom_t build_qtr_rom();
    qtr_rom_t t;
    real      x;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      x    = real'(AMPLITUDE) * $sin(QTR_STEP * real'(k));
      t[k] = MAG_W'($rtoi(x + 0.5));
    end
    return t;
  endfunction

endpackage

>>> src/ftfm_sine_rom.sv
module ftfm_sine_rom (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ftfm_pkg::ROM_AW-1:0] addr_i,
  output logic [ftfm_pkg::MAG_W-1:0]  data_o
);

  localparam ftfm_pkg::qtr_rom_t QTR_ROM = ftfm_pkg::build_qtr_rom();

  logic [ftfm_pkg::MAG_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= QTR_ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

>>> src/ftfm_seq.sv
module ftfm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  ftfm_pkg::op_e               op_i,
  input  logic [7:0]                  byte_i,
  input  ftfm_pkg::cfg_t              cfg_i,
  output ftfm_pkg::flags_t            flags_o,
  output logic [ftfm_pkg::ROM_AW-1:0] rom_addr_o
);

  ftfm_pkg::mode_e mode_q, mode_d;
  logic [31:0] phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [3:0]  tidx_q, tidx_d;
  logic [7:0]  shift_q, shift_d;

  logic [ftfm_pkg::SINE_ADDR_BITS-1:0] k;
  logic [ftfm_pkg::QTR_BITS-1:0]       r;
  logic [16:0] len;
  logic [16:0] cnt;
  logic [30:0] inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ftfm_pkg::MODE_IDLE;
      phase_q <= '0;
      count_q <= '0;
      tidx_q  <= '0;
      shift_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      count_q <= count_d;
      tidx_q  <= tidx_d;
      shift_q <= shift_d;
    end
  end

  // Mirror odd quadrants into the quarter table
  assign k = phase_q[31 -: ftfm_pkg::SINE_ADDR_BITS];
  assign r = k[ftfm_pkg::QTR_BITS-1:0];
  assign rom_addr_o = k[ftfm_pkg::QTR_BITS]
                    ? ftfm_pkg::ROM_AW'(ftfm_pkg::QTR_SIZE) - {1'b0, r}
                    : {1'b0, r};

  assign len = {(cfg_i.tone_samples == 16'd0), cfg_i.tone_samples};
  assign cnt = {1'b0, count_q} + 17'd1;

  always_comb begin
    case (mode_q)
      ftfm_pkg::MODE_START: inc = cfg_i.inc_start;
      ftfm_pkg::MODE_END:   inc = cfg_i.inc_end;
      default: begin
        if (tidx_q[0])     inc = cfg_i.inc_separator;
        else if (shift_q[7]) inc = cfg_i.inc_one;
        else               inc = cfg_i.inc_zero;
      end
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    count_d = count_q;
    tidx_d  = tidx_q;
    shift_d = shift_q;
    flags_o = '0;
    flags_o.negate = k[ftfm_pkg::SINE_ADDR_BITS-1];
    if (op_i != ftfm_pkg::OP_TICK) begin
      if (mode_q == ftfm_pkg::MODE_IDLE) begin
        flags_o.accepted = 1'b1;
        mode_d  = ftfm_pkg::mode_e'(op_i);
        phase_d = '0;
        count_d = '0;
        tidx_d  = '0;
        if (op_i == ftfm_pkg::OP_DATA) begin
          shift_d = byte_i;
        end
      end
    end else if (mode_q != ftfm_pkg::MODE_IDLE) begin
      flags_o.sample_valid = 1'b1;
      phase_d = phase_q + {1'b0, inc};
      count_d = cnt[15:0];
      if (cnt >= len) begin
        phase_d = '0;
        count_d = '0;
        if (mode_q == ftfm_pkg::MODE_DATA && tidx_q != 4'd15) begin
          if (tidx_q[0]) begin
            shift_d = {shift_q[6:0], 1'b0};
          end
          tidx_d = tidx_q + 4'd1;
        end else begin
          mode_d = ftfm_pkg::MODE_IDLE;
          tidx_d = '0;
          flags_o.last = 1'b1;
        end
      end
    end
    flags_o.busy = (mode_d != ftfm_pkg::MODE_IDLE);
  end

endmodule

>>> src/fsk_tone_frame_modulator.sv
// Binary FSK tone-frame modulator.
// Input channel (in_valid_i/in_ready_o) carries one word per command or tick:
// operation_i selects sample tick, start marker, data byte or end marker;
// data_byte_i is used by the data command. Each accepted word returns exactly
// one output word (out_valid_o/out_ready_i) holding the sine sample and the
// sample_valid, last, accepted and busy_res flags.
// Configuration (tone length, five phase increments) is written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do so only while no word is
// in flight; the block does not enforce it. Pipeline: sequencer update and
// quarter-wave ROM read, then negate into the output register. Throughput:
// one word per cycle unless the receiver stalls; the sequencer state advances
// in the accept cycle, so consecutive ticks need no interlock.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// only while the output register is full and out_ready_i is low.
// Reset: sequencer idle, phase and counters cleared, registers at defaults,
// pipeline empty. No clearing pass is needed; the ROM is constant.
module fsk_tone_frame_modulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          operation_i,
  input  logic [7:0]                          data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ftfm_pkg::SAMPLE_WIDTH-1:0] sample_o,
  output logic                                sample_valid_o,
  output logic                                last_o,
  output logic                                accepted_o,
  output logic                                busy_res_o,
  input  logic                                cfg_we_i,
  input  logic [ftfm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ftfm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  ftfm_pkg::cfg_t   cfg_q;
  ftfm_pkg::flags_t seq_flags;
  ftfm_pkg::flags_t s1_flags_q;
  logic             s1_valid_q;
  logic             advance;
  logic             fire;

  logic [ftfm_pkg::ROM_AW-1:0] rom_addr;
  logic [ftfm_pkg::MAG_W-1:0]  rom_mag;
  logic [ftfm_pkg::SAMPLE_WIDTH-1:0] mag_ext;

  logic                              out_valid_q;
  logic [ftfm_pkg::SAMPLE_WIDTH-1:0] sample_q, sample_d;
  logic                              sample_valid_q, last_q, accepted_q, busy_q;

  // Whole pipeline moves together; hold everything while output is stuck.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign fire       = in_valid_i && advance;

  // Configuration registers, full 31-bit write for increments.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_samples  <= ftfm_pkg::TONE_SAMPLES_RST;
      cfg_q.inc_one       <= ftfm_pkg::INC_ONE_RST;
      cfg_q.inc_zero      <= ftfm_pkg::INC_ZERO_RST;
      cfg_q.inc_separator <= ftfm_pkg::INC_SEPARATOR_RST;
      cfg_q.inc_start     <= ftfm_pkg::INC_START_RST;
      cfg_q.inc_end       <= ftfm_pkg::INC_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftfm_pkg::REG_TONE_SAMPLES:  cfg_q.tone_samples  <= cfg_wdata_i[15:0];
        ftfm_pkg::REG_INC_ONE:       cfg_q.inc_one       <= cfg_wdata_i;
        ftfm_pkg::REG_INC_ZERO:      cfg_q.inc_zero      <= cfg_wdata_i;
        ftfm_pkg::REG_INC_SEPARATOR: cfg_q.inc_separator <= cfg_wdata_i;
        ftfm_pkg::REG_INC_START:     cfg_q.inc_start     <= cfg_wdata_i;
        ftfm_pkg::REG_INC_END:       cfg_q.inc_end       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ftfm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .op_i       (ftfm_pkg::op_e'(operation_i)),
    .byte_i     (data_byte_i),
    .cfg_i      (cfg_q),
    .flags_o    (seq_flags),
    .rom_addr_o (rom_addr)
  );

  // Quarter-wave table read lines up with stage 1 flags.
  ftfm_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (rom_addr),
    .data_o (rom_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_flags_q <= seq_flags;
    end
  end

  // Apply the sign of the lower half-turn; drop the sample when not valid.
  assign mag_ext = {1'b0, rom_mag};

  always_comb begin
    if (!s1_flags_q.sample_valid) begin
      sample_d = '0;
    end else if (s1_flags_q.negate) begin
      sample_d = '0 - mag_ext;
    end else begin
      sample_d = mag_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_q       <= sample_d;
      sample_valid_q <= s1_flags_q.sample_valid;
      last_q         <= s1_flags_q.last;
      accepted_q     <= s1_flags_q.accepted;
      busy_q         <= s1_flags_q.busy;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign sample_valid_o = sample_valid_q;
  assign last_o         = last_q;
  assign accepted_o     = accepted_q;
  assign busy_res_o     = busy_q;

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ftfm_pkg::*;

  // One result word as the block should return it
  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_valid;
    logic                           last;
    logic                           accepted;
    logic                           busy;
  } tone_word_t;

  // Tone sequencer and NCO predictor plus the queue of result words still owed.
  // Hold its own register copy; the bench updates it only while no word is in flight.
  class fsk_tone_checker;
    int unsigned               qmag [0:QTR_SIZE];
    cfg_t                      regs;
    mode_e                     mode;
    logic [31:0]               phase;
    logic [15:0]               count;
    logic [3:0]                tone;
    logic [7:0]                shreg;
    tone_word_t                words_due [$];
    int unsigned               errors;

    function new();
      real quarter;
      quarter = $acos(0.0);
      for (int k = 0; k <= QTR_SIZE; k++) begin
        qmag[k] = $rtoi(real'(AMPLITUDE) * $sin(quarter * real'(k) / real'(QTR_SIZE)) + 0.5);
      end
      regs.tone_samples  = TONE_SAMPLES_RST;
      regs.inc_one       = INC_ONE_RST;
      regs.inc_zero      = INC_ZERO_RST;
      regs.inc_separator = INC_SEPARATOR_RST;
      regs.inc_start     = INC_START_RST;
      regs.inc_end       = INC_END_RST;
      mode   = MODE_IDLE;
      phase  = '0;
      count  = '0;
      tone   = '0;
      shreg  = '0;
      errors = 0;
    endfunction

    function logic signed [SAMPLE_WIDTH-1:0] tone_sample(logic [31:0] ph);
      logic [SINE_ADDR_BITS-1:0] k;
      logic [QTR_BITS-1:0]       r;
      logic [SAMPLE_WIDTH-1:0]   mag;
      k   = ph[31 -: SINE_ADDR_BITS];
      r   = k[QTR_BITS-1:0];
      // Mirror on odd quadrants, negate on the second half turn
      mag = SAMPLE_WIDTH'(k[QTR_BITS] ? qmag[QTR_SIZE - r] : qmag[r]);
      return k[QTR_BITS+1] ? -mag : mag;
    endfunction

    function logic [31:0] phase_step();
      logic [30:0] v;
      if (mode == MODE_START) v = regs.inc_start;
      else if (mode == MODE_END) v = regs.inc_end;
      else if (tone[0]) v = regs.inc_separator;
      else v = shreg[7] ? regs.inc_one : regs.inc_zero;
      return {1'b0, v};
    endfunction

    function void note_word(op_e op, logic [7:0] b);
      tone_word_t  w;
      int unsigned len;
      int unsigned cnt;
      w = '{sample: '0, sample_valid: 1'b0, last: 1'b0, accepted: 1'b0, busy: 1'b0};
      if (op != OP_TICK) begin
        if (mode == MODE_IDLE) begin
          w.accepted = 1'b1;
          mode  = mode_e'(op);
          phase = '0;
          count = '0;
          tone  = '0;
          if (op == OP_DATA) shreg = b;
        end
      end else if (mode != MODE_IDLE) begin
        len = (regs.tone_samples == '0) ? 32'd65536 : 32'(regs.tone_samples);
        cnt = 32'(count) + 1;
        w.sample       = tone_sample(phase);
        w.sample_valid = 1'b1;
        phase = phase + phase_step();
        count = cnt[15:0];
        if (cnt >= len) begin
          phase = '0;
          count = '0;
          if (mode == MODE_DATA && tone < 4'd15) begin
            if (tone[0]) shreg = shreg << 1;
            tone = tone + 4'd1;
          end else begin
            mode   = MODE_IDLE;
            tone   = '0;
            w.last = 1'b1;
          end
        end
      end
      w.busy = (mode != MODE_IDLE);
      words_due.push_back(w);
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_word(logic signed [SAMPLE_WIDTH-1:0] s, logic sv, logic lst,
                             logic acc, logic bsy);
      tone_word_t w;
      if (words_due.size() == 0) begin
        errors++;
        $error("unexpected output word, sample %0d", s);
        return;
      end
      w = words_due.pop_front();
      if (s !== w.sample) mismatch("sample", int'(w.sample), int'(s));
      if (sv !== w.sample_valid) mismatch("sample_valid", w.sample_valid, sv);
      if (lst !== w.last) mismatch("last", w.last, lst);
      if (acc !== w.accepted) mismatch("accepted", w.accepted, acc);
      if (bsy !== w.busy) mismatch("busy_res", w.busy, bsy);
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  op_e                            operation = OP_TICK;
  logic [7:0]                     data_byte = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           sample_valid;
  logic                           last;
  logic                           accepted;
  logic                           busy_res;
  logic                           cfg_we    = 1'b0;
  reg_idx_e                       cfg_idx   = REG_TONE_SAMPLES;
  logic [CFG_DATA_W-1:0]          cfg_wdata = '0;

  fsk_tone_checker sb;
  bit              quiet = 1'b0;   // no idling on either side while set
  int              stall_left = 0;
  int unsigned     words_sent = 0;

  always #10 clk = ~clk;

  fsk_tone_frame_modulator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sample_o       (sample),
    .sample_valid_o (sample_valid),
    .last_o         (last),
    .accepted_o     (accepted),
    .busy_res_o     (busy_res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Receiver: drop ready in random bursts, never while quiet
  always @(negedge clk) begin
    if (quiet) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result word on the edge that takes it
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(sample, sample_valid, last, accepted, busy_res);
    end
  end

  // Offer one word and hold it until the block takes it; enter and leave on a
  // falling edge. Valid is only lowered for a gap, so it never bounces in one step.
  task automatic send_word(op_e op, logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(op, b);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic op_e pick_command();
    case ($urandom_range(0, 2))
      0:       return OP_START;
      1:       return OP_DATA;
      default: return OP_END;
    endcase
  endfunction

  // Mostly short tones so data bytes stay cheap; now and then a long one
  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 9))
      7, 8:    return 16'($urandom_range(5, 24));
      9:       return 16'($urandom_range(25, 60));
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [30:0] pick_inc();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic ticks(int n);
    repeat (n) send_word(OP_TICK, 8'($urandom()));
  endtask

  // Tick until the sequence is over; sprinkle commands that must be refused
  task automatic run_out(int junk_pct);
    while (sb.mode != MODE_IDLE) begin
      if ($urandom_range(0, 99) < junk_pct) send_word(pick_command(), 8'($urandom()));
      else send_word(OP_TICK, 8'($urandom()));
    end
  endtask

  task automatic frame(op_e op, logic [7:0] b, int junk_pct);
    send_word(op, b);
    run_out(junk_pct);
  endtask

  // Drop valid and wait until every owed word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.words_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write all six registers back to back with nothing in flight
  task automatic apply(cfg_t s);
    reg_idx_e r;
    settle();
    r = REG_TONE_SAMPLES;
    do begin
      cfg_we  <= 1'b1;
      cfg_idx <= r;
      case (r)
        REG_TONE_SAMPLES:  cfg_wdata <= CFG_DATA_W'(s.tone_samples);
        REG_INC_ONE:       cfg_wdata <= s.inc_one;
        REG_INC_ZERO:      cfg_wdata <= s.inc_zero;
        REG_INC_SEPARATOR: cfg_wdata <= s.inc_separator;
        REG_INC_START:     cfg_wdata <= s.inc_start;
        default:           cfg_wdata <= s.inc_end;
      endcase
      @(negedge clk);
      r = r.next();
    end while (r != REG_TONE_SAMPLES);
    cfg_we  <= 1'b0;
    sb.regs = s;
    @(negedge clk);
  endtask

  task automatic shuffle_incs(ref cfg_t c);
    c.inc_one       = pick_inc();
    c.inc_zero      = pick_inc();
    c.inc_separator = pick_inc();
    c.inc_start     = pick_inc();
    c.inc_end       = pick_inc();
  endtask

  initial begin
    cfg_t        c;
    int unsigned goal;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ticks while idle return an all-zero word
    ticks(2);
    // Start tone on reset settings; commands while busy are refused
    send_word(OP_START, 8'h00);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_END, 8'h00);
    ticks(30);
    // Cut the start tone short, then a data byte and an end tone on reset increments
    c = sb.regs;
    c.tone_samples = 16'd4;
    apply(c);
    run_out(0);
    frame(OP_DATA, 8'hA5, 0);
    frame(OP_END, 8'h00, 0);

    // Shortest tones, then the increment extremes
    c = sb.regs;
    c.tone_samples = 16'd1;
    apply(c);
    frame(OP_DATA, 8'hA5, 0);
    c.inc_one  = '1;
    c.inc_zero = '0;
    apply(c);
    frame(OP_DATA, 8'hFF, 0);
    frame(OP_DATA, 8'h00, 0);
    frame(OP_END, 8'h5A, 0);
    c.tone_samples  = 16'd3;
    c.inc_separator = '1;
    c.inc_start     = '0;
    c.inc_end       = '1;
    apply(c);
    frame(OP_DATA, 8'h80, 10);
    frame(OP_DATA, 8'h01, 10);
    frame(OP_START, 8'hC3, 10);
    frame(OP_END, 8'h3C, 10);

    // Register write in the middle of a data tone: shorter length ends it at once
    c.tone_samples = 16'd8;
    c.inc_one      = INC_ONE_RST;
    apply(c);
    send_word(OP_DATA, 8'h3C);
    ticks(20);
    c.tone_samples = 16'd2;
    c.inc_one      = pick_inc();
    apply(c);
    run_out(0);

    // Longest length, then zero (65536) mid-tone, then cut it short
    c.tone_samples = 16'hFFFF;
    apply(c);
    send_word(OP_START, 8'h00);
    ticks(40);
    c.tone_samples = 16'd0;
    apply(c);
    ticks(30);
    c.tone_samples = 16'd1;
    apply(c);
    ticks(2);

    // Random phases: mostly whole sequences, some loose and clashing words
    for (int p = 0; p < 6; p++) begin
      c.tone_samples = pick_len();
      shuffle_incs(c);
      apply(c);
      quiet = ($urandom_range(0, 3) == 0);
      goal  = words_sent + 170;
      while (words_sent < goal) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 0) send_word(OP_TICK, 8'($urandom()));
            else send_word(pick_command(), 8'($urandom()));
          end
        end else begin
          frame(pick_command(), 8'($urandom()), 5);
          ticks($urandom_range(0, 2));
        end
      end
    end

    // Last part, no idling: short frames back to back on fixed settings
    c.tone_samples = 16'd2;
    shuffle_incs(c);
    apply(c);
    quiet = 1'b1;
    frame(OP_DATA, 8'($urandom()), 0);
    frame(OP_END, 8'($urandom()), 0);
    frame(OP_START, 8'($urandom()), 0);
    ticks(1);

    settle();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.words_due.size() == 0) begin
      $display("PASS fsk_tone_frame_modulator");
    end else begin
      $display("FAIL fsk_tone_frame_modulator");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #16_000_000;
    $display("FAIL fsk_tone_frame_modulator");
    $finish;
  end

endmodule
